[design/pffl_pkg.sv]
// Package for the page frame free list allocator.
// Transaction payload types, status and operation codes, controller/datapath links.
// No dependencies.
package pffl_pkg;

    localparam int FRAME_W        = 8;
    localparam int COUNT_W        = 7;
    localparam int CFG_W          = 9;
    localparam int MAX_FRAMES_DEF = 256;
    localparam int MAX_BURST_DEF  = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FRAMES = 2'd1,
        ST_BAD_FRAME = 2'd2
    } t_status;

    typedef struct packed {
        logic               operation;
        logic [COUNT_W-1:0] count;
        logic [FRAME_W-1:0] frame_to_free;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [FRAME_W-1:0] frame_number;
        logic               frame_valid;
        logic               last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic start_burst;
        logic emit_single;
        logic rd_issue;
        logic pop;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eval_burst;
        logic slot_free;
        logic pop_last;
    } t_dp_stat;

endpackage

[design/pffl_ctrl.sv]
// Controller state machine of the page frame free list allocator.
// Depends on pffl_pkg (command and status structs).
module pffl_ctrl
    import pffl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_stat  i_stat,
    output logic      o_in_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.eval_burst) begin
                    o_cmd.start_burst = 1'b1;
                    n_state           = S_READ;
                end else if (i_stat.slot_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_stat.pop_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/pffl_dpath.sv]
// Datapath of the page frame free list allocator: link store, list state, output register.
// Depends on pffl_pkg (payload types, codes, command and status structs).
module pffl_dpath
    import pffl_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_item         i_in_item,
    input  logic             i_out_ready,
    input  t_ctrl_cmd        i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    output t_out_item        o_out_item
);

    localparam int FRAME_LIMIT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
    localparam int DEPTH       = FRAME_LIMIT;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW          = (MAX_BURST > 1) ? $clog2(MAX_BURST + 1) : 1;

    function automatic logic [FRAME_W-1:0] safe_frame(input logic [FRAME_W-1:0] f);
        return (32'(f) < MAX_FRAMES) ? f : '0;
    endfunction

    // link store; entries not yet written read as their successor frame
    logic [FRAME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_lvalid;
    logic [FRAME_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;

    logic [CFG_W-1:0]   r_fiu;
    logic [FRAME_W-1:0] r_head;
    logic               r_empty;
    logic [CFG_W-1:0]   r_free_cnt;
    logic [BW-1:0]      r_remain;
    t_in_item           r_item;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CFG_W-1:0]   cfg_val;
    logic               f_bad;
    logic               alloc_fail;
    logic               cnt_zero;
    logic               do_free;
    logic [AW-1:0]      free_addr;
    logic [AW-1:0]      rd_addr;
    logic [FRAME_W-1:0] link;
    t_status            single_status;

    always_comb begin
        cfg_val = i_cfg_wdata;
        if (cfg_val == '0) begin
            cfg_val = CFG_W'(1);
        end else if (cfg_val > CFG_W'(FRAME_LIMIT)) begin
            cfg_val = CFG_W'(FRAME_LIMIT);
        end
    end

    assign f_bad      = CFG_W'(r_item.frame_to_free) >= r_fiu;
    assign cnt_zero   = (r_item.count == '0);
    assign alloc_fail = (r_item.count > COUNT_W'(MAX_BURST))
                     || (CFG_W'(r_item.count) > r_free_cnt)
                     || (!cnt_zero && r_empty);

    always_comb begin
        if (r_item.operation == OP_FREE) begin
            single_status = f_bad ? ST_BAD_FRAME : ST_OK;
        end else begin
            single_status = alloc_fail ? ST_NO_FRAMES : ST_OK;
        end
    end

    assign do_free   = i_cmd.emit_single && (r_item.operation == OP_FREE) && !f_bad;
    assign free_addr = r_item.frame_to_free[AW-1:0];
    assign rd_addr   = r_head[AW-1:0];
    assign link      = r_rd_vld ? r_rd_data : (FRAME_W'(r_rd_addr) + FRAME_W'(1));

    assign o_stat.eval_burst = (r_item.operation == OP_ALLOC) && !alloc_fail && !cnt_zero;
    assign o_stat.slot_free  = !r_out_valid || i_out_ready;
    assign o_stat.pop_last   = (r_remain == BW'(1));

    // link store data, no reset
    always_ff @(posedge i_clk) begin
        if (do_free) begin
            r_mem[free_addr] <= r_empty ? r_item.frame_to_free : r_head;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_lvalid[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_lvalid <= '0;
        end else if (do_free) begin
            r_lvalid[free_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu      <= CFG_W'(FRAME_LIMIT);
            r_head     <= '0;
            r_empty    <= 1'b0;
            r_free_cnt <= CFG_W'(FRAME_LIMIT);
        end else if (i_cfg_we) begin
            r_fiu      <= cfg_val;
            r_head     <= '0;
            r_empty    <= 1'b0;
            r_free_cnt <= cfg_val;
        end else if (do_free) begin
            r_head  <= r_item.frame_to_free;
            r_empty <= 1'b0;
            if (r_free_cnt < r_fiu) begin
                r_free_cnt <= r_free_cnt + CFG_W'(1);
            end
        end else if (i_cmd.pop) begin
            r_head     <= safe_frame(link);
            r_free_cnt <= r_free_cnt - CFG_W'(1);
            if (o_stat.pop_last && (r_free_cnt == CFG_W'(1))) begin
                r_empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.start_burst) begin
            r_remain <= r_item.count[BW-1:0];
        end else if (i_cmd.pop) begin
            r_remain <= r_remain - BW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_out.status       <= single_status;
            r_out.frame_number <= '0;
            r_out.frame_valid  <= 1'b0;
            r_out.last         <= 1'b1;
        end else if (i_cmd.pop) begin
            r_out.status       <= ST_OK;
            r_out.frame_number <= r_head;
            r_out.frame_valid  <= 1'b1;
            r_out.last         <= o_stat.pop_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[design/page_frame_free_list_allocator.sv]
// Top level of the page frame free list allocator.
// Depends on pffl_pkg, pffl_ctrl and pffl_dpath.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_item): one transaction is an
//    allocate of count frames or a free of one frame.
//  - Output channel (o_out_valid / i_out_ready / o_out_item): one transaction per
//    allocated frame (last marks the final one), or a single status transaction
//    for a free, a failed allocate or a zero-count allocate.
//  - Config: i_cfg_we with i_cfg_wdata sets frames_in_use (clamped to 1..limit)
//    and rebuilds the list with every frame free. Write only while idle.
//  - Timing: a single-result item is evaluated once and its result is registered
//    in the output register; an allocate burst is evaluated, then each frame
//    takes one registered link-store read plus one pop. Both wait while the
//    output register cannot take a result.
//  - Inputs are taken only by the idle controller; one item is in work at a time,
//    and the next can be taken while the last result still sits in the output reg.
//  - Reset: list holds every frame in ascending order, frame 0 at the head. Link
//    entries carry per-entry valid bits, so no clearing pass is needed.
//  - Receiver stall: the output register holds its transaction and the burst waits.
module page_frame_free_list_allocator
    import pffl_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencing: idle -> evaluate -> (read link -> pop) per frame
    pffl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // list state, link store and output register
    pffl_dpath #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_BURST  (MAX_BURST)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // a result is only loaded when the output slot can take it
    a_load_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pop || cmd.emit_single) |-> (!o_out_valid || i_out_ready))
        else $error("result loaded into a busy output register");

    // at most one datapath action per cycle
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start_burst, cmd.emit_single, cmd.pop, cmd.rd_issue}))
        else $error("conflicting datapath commands");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // final pop of a burst shows up marked last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pop && stat.pop_last) |=> (o_out_valid && o_out_item.last))
        else $error("final frame of a burst not marked last");

endmodule

[verif/page_frame_free_list_allocator_test.sv]
// Self-checking testbench for page_frame_free_list_allocator.
// Predicts each result transaction from its own copy of the free list.
// Depends on pffl_pkg and the allocator RTL.
module page_frame_free_list_allocator_test;
    import pffl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;          // drain time after the last owed result comes back
    localparam int CYCLE_LIMIT   = 8_000_000;  // worst case: every item a 64-frame burst
    localparam int PHASE_ITEMS   = 60;
    localparam int LIST_SIZE     = 256;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_ready = 1'b1;
    t_out_item        o_out_item;

    page_frame_free_list_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #1ns i_clk = ~i_clk;

    // Shadow copy of the allocator's free list
    logic [8:0]         shadow_frames;          // frames_in_use after clamping
    logic [FRAME_W-1:0] shadow_link [LIST_SIZE];
    logic [FRAME_W-1:0] shadow_head;
    logic               shadow_empty;
    logic [8:0]         shadow_free;

    t_out_item          expected_grants [$];    // result transactions still owed
    logic [FRAME_W-1:0] held_frames [$];        // frames handed out, for well-formed frees

    int  failures     = 0;
    int  n_requests   = 0;
    int  n_allocs     = 0;
    int  n_frees      = 0;
    int  n_refused    = 0;
    int  n_results    = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    bit  steady_flow  = 1'b0;                   // no gaps on either side while set

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(16, 40);
    endfunction

    // Clamp the register value and put every frame back on the list, in order
    task automatic rebuild_shadow(input logic [CFG_W-1:0] value);
        if (value == 0)
            shadow_frames = 9'd1;
        else if (value > LIST_SIZE)
            shadow_frames = 9'(LIST_SIZE);
        else
            shadow_frames = value;
        for (int i = 0; i < LIST_SIZE; i++)
            shadow_link[i] = FRAME_W'(i + 1);
        shadow_head  = '0;
        shadow_empty = 1'b0;
        shadow_free  = shadow_frames;
        held_frames.delete();
    endtask

    // Append one owed result transaction
    task automatic owe_result(input t_out_item item);
        expected_grants = {expected_grants, item};
    endtask

    // Apply one accepted request to the shadow list and queue its results
    task automatic predict_request(input t_in_item req);
        t_out_item          res;
        logic [FRAME_W-1:0] f;
        int                 pos;
        res.status       = ST_OK;
        res.frame_number = '0;
        res.frame_valid  = 1'b0;
        res.last         = 1'b1;
        f                = req.frame_to_free;
        pos              = -1;
        if (req.operation == OP_FREE) begin
            n_frees++;
            if ({1'b0, f} >= shadow_frames) begin
                res.status = ST_BAD_FRAME;
            end else begin
                // push on head; an empty list gets a self link
                shadow_link[f] = shadow_empty ? f : shadow_head;
                shadow_head    = f;
                shadow_empty   = 1'b0;
                if (shadow_free < shadow_frames)
                    shadow_free++;
                foreach (held_frames[i])
                    if (pos < 0 && held_frames[i] == f)
                        pos = i;
                if (pos >= 0)
                    held_frames.delete(pos);
            end
            owe_result(res);
        end else begin
            n_allocs++;
            if (req.count > MAX_BURST_DEF || req.count > shadow_free ||
                (req.count != 0 && shadow_empty)) begin
                res.status = ST_NO_FRAMES;
                owe_result(res);
            end else if (req.count == 0) begin
                owe_result(res);
            end else begin
                for (int i = 0; i < req.count; i++) begin
                    res.frame_number = shadow_head;
                    res.frame_valid  = 1'b1;
                    res.last         = (i == req.count - 1);
                    owe_result(res);
                    held_frames = {held_frames, shadow_head};
                    shadow_head = shadow_link[shadow_head];
                    shadow_free--;
                end
                if (shadow_free == 0)
                    shadow_empty = 1'b1;
            end
        end
        if (res.status != ST_OK)
            n_refused++;
    endtask

    // One input transaction; valid stays up across back-to-back requests
    task automatic send_request(input t_in_item req);
        int gap;
        i_in_item  <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_request(req);
        n_requests++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic request_alloc(input int n);
        t_in_item req;
        req.operation     = OP_ALLOC;
        req.count         = COUNT_W'(n);
        req.frame_to_free = FRAME_W'($urandom);   // ignored by allocate
        send_request(req);
    endtask

    task automatic request_free(input int f);
        t_in_item req;
        req.operation     = OP_FREE;
        req.count         = COUNT_W'($urandom);   // ignored by free
        req.frame_to_free = FRAME_W'(f);
        send_request(req);
    endtask

    // Block is idle once every owed result is back and the pipeline has drained
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        rebuild_shadow(value);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: small bursts and frees of frames we hold;
    // the rest is oversized counts, stray frame numbers and double frees.
    function automatic t_in_item next_random_request();
        t_in_item req;
        int       r;
        int       c;
        int       hi;
        r  = $urandom_range(0, 99);
        c  = $urandom_range(0, 99);
        hi = (shadow_free > MAX_BURST_DEF) ? MAX_BURST_DEF : int'(shadow_free);
        req.count         = COUNT_W'($urandom);
        req.frame_to_free = FRAME_W'($urandom);
        if (r < 45) begin
            req.operation = OP_ALLOC;
            if (c < 60)
                req.count = COUNT_W'($urandom_range(1, 4));
            else if (c < 80)
                req.count = (hi == 0) ? COUNT_W'(1) : COUNT_W'($urandom_range(1, hi));
            else if (c < 90)
                req.count = COUNT_W'($urandom_range(0, MAX_BURST_DEF));
            else if (c < 95)
                req.count = '0;
            else
                req.count = COUNT_W'($urandom_range(MAX_BURST_DEF + 1,
                                                    (1 << COUNT_W) - 1));
        end else if (r < 85) begin
            req.operation = OP_FREE;
            if (held_frames.size() != 0)
                req.frame_to_free = held_frames[$urandom_range(0, held_frames.size() - 1)];
            else
                req.frame_to_free = FRAME_W'($urandom_range(0, shadow_frames - 1));
        end else begin
            req.operation = OP_FREE;   // anything goes, range errors and double frees
        end
        return req;
    endfunction

    // Bursts at the edges of the burst limit, then frees that relink the head
    task automatic test_burst_limits();
        request_alloc(0);
        request_alloc(1);
        request_alloc(MAX_BURST_DEF);
        request_alloc(MAX_BURST_DEF + 1);
        request_alloc((1 << COUNT_W) - 1);
        request_free(LIST_SIZE - 1);   // still on the list: a double free
        request_free(0);
        request_free(MAX_BURST_DEF);
        request_alloc(3);
        wait_for_idle();
    endtask

    // A single frame: empty list, range check, saturating free count
    task automatic test_frame_count_extremes();
        write_frame_count('0);
        request_alloc(1);
        request_alloc(1);
        request_free(1);
        request_free(LIST_SIZE - 1);
        request_free(0);
        request_free(0);
        request_alloc(2);
        request_alloc(1);
        request_alloc(0);
        wait_for_idle();
    endtask

    // Drain all 256 frames, then bring one back
    task automatic test_exhaust_and_refill();
        write_frame_count('1);
        repeat (LIST_SIZE / MAX_BURST_DEF) request_alloc(MAX_BURST_DEF);
        request_alloc(1);
        request_alloc(0);
        request_free(200);
        request_alloc(1);
        wait_for_idle();
    endtask

    // Random traffic across a spread of frame counts, some phases without gaps
    task automatic test_random_traffic();
        logic [CFG_W-1:0] settings [8];
        settings = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd511, 9'd5, 9'd64, 9'd257};
        settings[5] = CFG_W'($urandom_range(3, 63));
        settings[6] = CFG_W'($urandom_range(64, 255));
        for (int p = 0; p < 8; p++) begin
            write_frame_count(settings[p]);
            steady_flow = (p % 3 == 2);
            repeat (PHASE_ITEMS) send_request(next_random_request());
            steady_flow = 1'b0;
            wait_for_idle();
        end
    endtask

    // Receiver side: random stalls on o_out_valid
    always @(posedge i_clk) begin
        if (!i_rst_n || steady_flow) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare every result transaction with the oldest owed one
    always @(posedge i_clk) begin : check_grants
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            n_results++;
            if (expected_grants.size() == 0) begin
                failures++;
                $display("%0t unexpected result: status=%0d frame=%0d valid=%0b last=%0b",
                         $time, o_out_item.status, o_out_item.frame_number,
                         o_out_item.frame_valid, o_out_item.last);
            end else begin
                want = expected_grants.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.frame_number !== want.frame_number ||
                    o_out_item.frame_valid !== want.frame_valid ||
                    o_out_item.last !== want.last) begin
                    failures++;
                    $display({"%0t mismatch: expected status=%0d frame=%0d valid=%0b ",
                              "last=%0b, got status=%0d frame=%0d valid=%0b last=%0b"},
                             $time, want.status, want.frame_number, want.frame_valid,
                             want.last, o_out_item.status, o_out_item.frame_number,
                             o_out_item.frame_valid, o_out_item.last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_grants.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        rebuild_shadow(CFG_W'(LIST_SIZE));
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_burst_limits();
        test_frame_count_extremes();
        test_exhaust_and_refill();
        test_random_traffic();
        wait_for_idle();

        $display("covered %0d requests (%0d allocates, %0d frees), %0d refused",
                 n_requests, n_allocs, n_frees, n_refused);
        $display("checked %0d result transactions over 11 frame-count settings, %0d errors",
                 n_results, failures);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
